@@ hw/rtl/okvt_pkg.sv @@
// Shared types and constants of the ordered key/value table.
package okvt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned POS_BITS    = 8;
  localparam int unsigned STATUS_BITS = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT   = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_ERASE    = 3'd2,
    OP_LOOKUP   = 3'd3,
    OP_READ_POS = 3'd4
  } okvt_op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK          = 3'd0,
    ST_KEY_PRESENT = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_POS_RANGE   = 3'd4
  } okvt_status_e;

endpackage

@@ hw/rtl/okvt_if.sv @@
// Valid/ready channel interfaces for operations and results.
interface okvt_in_if #(
  parameter int unsigned KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [okvt_pkg::OP_BITS-1:0]  operation;
  logic [KEY_BITS-1:0]           key_in;
  logic [VALUE_BITS-1:0]         value_in;
  logic [okvt_pkg::POS_BITS-1:0] position;

  modport source (output valid, output operation, output key_in, output value_in,
                  output position, input ready);
  modport sink (input valid, input operation, input key_in, input value_in,
                input position, output ready);
endinterface

interface okvt_out_if #(
  parameter int unsigned KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = okvt_pkg::VALUE_BITS_DEF,
  parameter int unsigned CNT_BITS   = 5
) ();
  logic                             valid;
  logic                             ready;
  logic [okvt_pkg::STATUS_BITS-1:0] status;
  logic [KEY_BITS-1:0]              key_out;
  logic [VALUE_BITS-1:0]            value_out;
  logic [CNT_BITS-1:0]              entry_count;

  modport source (output valid, output status, output key_out, output value_out,
                  output entry_count, input ready);
  modport sink (input valid, input status, input key_out, input value_out,
                input entry_count, output ready);
endinterface

@@ hw/rtl/ordered_key_value_table.sv @@
// Path: an accepted operation waits in the input register, executes once the result
//   register is free, and its result then waits in the result register for the sink.
// Throughput: one operation per cycle while the sink takes results, set by the parallel
//   match and shift of the entry registers between the input and result registers.
// Stall: while a result waits, the input register still takes one transfer if it is
//   empty; input ready then stays low until the sink takes the waiting result.
// Reset: rst_ni asynchronous active low; table empty, both stages empty.
module ordered_key_value_table #(
  parameter int unsigned TABLE_DEPTH = okvt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS  = okvt_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  okvt_in_if.sink    in_i,
  okvt_out_if.source out_o
);
  import okvt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // stage 1: held operation
  logic                  s1_valid;
  okvt_op_e              s1_op;
  logic [KEY_BITS-1:0]   s1_key;
  logic [VALUE_BITS-1:0] s1_value;
  logic [POS_BITS-1:0]   s1_pos;

  // table outputs for the held operation
  okvt_status_e          res_status;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;
  logic [CNT_W-1:0]      res_count;

  logic out_free;
  logic exec;

  // The held operation executes when the result register can take its result;
  // the table state and the result register update on the same edge.
  assign exec = s1_valid && out_free;

  okvt_in_stage #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .drain_i (out_free),
    .valid_o (s1_valid),
    .op_o    (s1_op),
    .key_o   (s1_key),
    .value_o (s1_value),
    .pos_o   (s1_pos)
  );

  okvt_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (exec),
    .op_i     (s1_op),
    .key_i    (s1_key),
    .value_i  (s1_value),
    .pos_i    (s1_pos),
    .status_o (res_status),
    .key_o    (res_key),
    .value_o  (res_value),
    .count_o  (res_count)
  );

  okvt_out_stage #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (exec),
    .status_i (res_status),
    .key_i    (res_key),
    .value_i  (res_value),
    .count_i  (res_count),
    .free_o   (out_free),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !exec)
    else $error("result overwritten while waiting for transfer");
  a_held_op_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !out_free |=> s1_valid && $stable(s1_key) && $stable(s1_op))
    else $error("held operation lost while output stalled");
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_o.valid)
    else $error("executed operation produced no result");
`endif

endmodule

@@ hw/rtl/okvt_in_stage.sv @@
// Input register: holds one accepted operation until the table takes it.
module okvt_in_stage #(
  parameter int unsigned KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  okvt_in_if.sink                       in_i,
  input  logic                          drain_i,
  output logic                          valid_o,
  output okvt_pkg::okvt_op_e            op_o,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [VALUE_BITS-1:0]         value_o,
  output logic [okvt_pkg::POS_BITS-1:0] pos_o
);
  import okvt_pkg::*;

  logic                  valid_q, valid_d;
  okvt_op_e              op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [POS_BITS-1:0]   pos_q;
  logic                  take;

  assign in_i.ready = !valid_q || drain_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = in_i.ready ? in_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q    <= okvt_op_e'(in_i.operation);
      key_q   <= in_i.key_in;
      value_q <= in_i.value_in;
      pos_q   <= in_i.position;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign pos_o   = pos_q;

endmodule

@@ hw/rtl/okvt_table.sv @@
// Entry store with parallel key match, front insert and gap-closing erase.
module okvt_table #(
  parameter int unsigned TABLE_DEPTH = okvt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS  = okvt_pkg::VALUE_BITS_DEF,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  okvt_pkg::okvt_op_e            op_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  logic [okvt_pkg::POS_BITS-1:0] pos_i,
  output okvt_pkg::okvt_status_e        status_o,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [VALUE_BITS-1:0]         value_o,
  output logic [CNT_W-1:0]              count_o
);
  import okvt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  logic [KEY_BITS-1:0]    keys_q [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    keys_d [TABLE_DEPTH];
  logic [VALUE_BITS-1:0]  vals_q [TABLE_DEPTH];
  logic [VALUE_BITS-1:0]  vals_d [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] live_q, live_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] at_or_after;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [VALUE_BITS-1:0]  hit_val;
  logic                   pos_ok;
  logic [IDX_W-1:0]       pos_idx;
  logic                   full;
  logic                   do_insert, do_update, do_erase;

  always_comb begin
    match   = '0;
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = live_q[i] && (keys_q[i] == key_i);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_val = hit_val | vals_q[i];
      end
    end
    hit = |match;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      at_or_after[i] = hit && (IDX_W'(i) >= hit_idx);
    end
  end

  assign pos_ok  = CMP_W'(pos_i) < CMP_W'(count_q);
  assign pos_idx = pos_i[IDX_W-1:0];
  assign full    = (count_q == CNT_W'(TABLE_DEPTH));

  // result and decision
  always_comb begin
    status_o  = ST_OK;
    key_o     = '0;
    value_o   = '0;
    do_insert = 1'b0;
    do_update = 1'b0;
    do_erase  = 1'b0;
    case (op_i)
      OP_INSERT: begin
        if (hit) begin
          status_o = ST_KEY_PRESENT;
        end else if (full) begin
          status_o = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (hit) do_update = 1'b1;
        else     status_o  = ST_NOT_FOUND;
      end
      OP_ERASE: begin
        if (hit) do_erase = 1'b1;
        else     status_o = ST_NOT_FOUND;
      end
      OP_LOOKUP: begin
        if (hit) value_o  = hit_val;
        else     status_o = ST_NOT_FOUND;
      end
      OP_READ_POS: begin
        if (pos_ok) begin
          key_o   = keys_q[pos_idx];
          value_o = vals_q[pos_idx];
        end else begin
          status_o = ST_POS_RANGE;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    keys_d  = keys_q;
    vals_d  = vals_q;
    live_d  = live_q;
    count_d = count_q;
    if (do_insert) begin
      keys_d[0] = key_i;
      vals_d[0] = value_i;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
        keys_d[i] = keys_q[i-1];
        vals_d[i] = vals_q[i-1];
      end
      live_d  = {live_q[TABLE_DEPTH-2:0], 1'b1};
      count_d = count_q + 1'b1;
    end else if (do_erase) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (at_or_after[i]) begin
          keys_d[i] = keys_q[i+1];
          vals_d[i] = vals_q[i+1];
          live_d[i] = live_q[i+1];
        end
      end
      if (at_or_after[TABLE_DEPTH-1]) live_d[TABLE_DEPTH-1] = 1'b0;
      count_d = count_q - 1'b1;
    end else if (do_update) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (match[i]) vals_d[i] = value_i;
      end
    end
  end

  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      count_q <= '0;
    end else if (en_i) begin
      live_q  <= live_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      keys_q <= keys_d;
      vals_q <= vals_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");
  a_live_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_q) == int'(count_q))
    else $error("live bits disagree with entry count");
  a_keys_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key matches more than one live entry");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && do_insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table by one");
  a_erase_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && do_erase |=> count_q == $past(count_q) - 1'b1)
    else $error("erase did not shrink the table by one");
`endif

endmodule

@@ hw/rtl/okvt_out_stage.sv @@
// Result register: holds one result until the sink takes the transfer.
module okvt_out_stage #(
  parameter int unsigned KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = okvt_pkg::VALUE_BITS_DEF,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  okvt_pkg::okvt_status_e status_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  logic [CNT_W-1:0]       count_i,
  output logic                   free_o,
  okvt_out_if.source             out_o
);
  import okvt_pkg::*;

  logic                  valid_q, valid_d;
  okvt_status_e          status_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CNT_W-1:0]      count_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_i;
      key_q    <= key_i;
      value_q  <= value_i;
      count_q  <= count_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.status      = status_q;
  assign out_o.key_out     = key_q;
  assign out_o.value_out   = value_q;
  assign out_o.entry_count = count_q;

endmodule

@@ tb/okvt_checker.sv @@
`timescale 1ns / 100ps
// Checker for the ordered key/value table: tracks the table and compares every result.
module okvt_checker #(
  parameter int unsigned TABLE_DEPTH = okvt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = okvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS  = okvt_pkg::VALUE_BITS_DEF,
  parameter int unsigned CNT_BITS    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  okvt_in_if.sink     op_i,
  okvt_out_if.sink    res_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o,
  output int unsigned compared_o
);
  import okvt_pkg::*;

  typedef struct {
    okvt_status_e          status;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_BITS-1:0]   count;
  } table_result_t;

  // Shadow table, newest entry at index 0; live entries are 0 .. live_count-1.
  logic [KEY_BITS-1:0]   shadow_keys [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] shadow_vals [TABLE_DEPTH];
  int unsigned           live_count;
  table_result_t         expected_results [$];

  function automatic int find_key(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < live_count; i++) begin
      if (shadow_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t apply_table_op(logic [OP_BITS-1:0] op,
                                                   logic [KEY_BITS-1:0] key,
                                                   logic [VALUE_BITS-1:0] value,
                                                   logic [POS_BITS-1:0] pos);
    table_result_t r;
    int hit;
    r.status = ST_OK;
    r.key    = '0;
    r.value  = '0;
    hit      = find_key(key);
    case (op)
      OP_INSERT: begin
        // duplicate check wins over the full check
        if (hit >= 0) r.status = ST_KEY_PRESENT;
        else if (live_count >= TABLE_DEPTH) r.status = ST_FULL;
        else begin
          for (int i = live_count; i > 0; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[0] = key;
          shadow_vals[0] = value;
          live_count++;
        end
      end
      OP_UPDATE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else shadow_vals[hit] = value;
      end
      OP_ERASE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          for (int i = hit; i + 1 < live_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          live_count--;
        end
      end
      OP_LOOKUP: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.value = shadow_vals[hit];
      end
      OP_READ_POS: begin
        if (pos >= live_count) r.status = ST_POS_RANGE;
        else begin
          r.key   = shadow_keys[pos];
          r.value = shadow_vals[pos];
        end
      end
      default: ; // unused codes leave the table alone
    endcase
    r.count = CNT_BITS'(live_count);
    return r;
  endfunction

  task automatic report_error(string msg);
    mismatches_o++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      live_count    = 0;
      expected_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      compared_o    = 0;
    end else begin
      if (op_i.valid && op_i.ready) begin
        expected_results.push_back(apply_table_op(op_i.operation, op_i.key_in,
                                                  op_i.value_in, op_i.position));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result with nothing pending (status %0d count %0d)",
                                 res_i.status, res_i.entry_count));
        end else begin
          want = expected_results.pop_front();
          compared_o++;
          if (res_i.status !== want.status)
            report_error($sformatf("status got %0d want %0d", res_i.status, want.status));
          if (res_i.key_out !== want.key)
            report_error($sformatf("key_out got %0h want %0h", res_i.key_out, want.key));
          if (res_i.value_out !== want.value)
            report_error($sformatf("value_out got %0h want %0h", res_i.value_out, want.value));
          if (res_i.entry_count !== want.count)
            report_error($sformatf("entry_count got %0d want %0d",
                                   res_i.entry_count, want.count));
        end
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the ordered key/value table testbench: stimulus, flow control and verdict.
module tb_top;
  import okvt_pkg::*;

  localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
  localparam int unsigned KEY_BITS      = KEY_BITS_DEF;
  localparam int unsigned VALUE_BITS    = VALUE_BITS_DEF;
  localparam int unsigned CNT_BITS      = 5;
  localparam int unsigned RAND_BLOCKS   = 10;     // random part, in blocks
  localparam int unsigned BLOCK_OPS     = 125;    // operations per block
  localparam int unsigned POOL_SIZE     = 24;     // more keys than slots, so full happens
  localparam int unsigned HOLD_CYCLES   = 80;     // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES  = 8;      // settle margin after the last result
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // codes 5..7 carry no name in the package; they must be ignored by the block
  localparam logic [OP_BITS-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_BITS-1:0] OP_LAST_UNUSED  = {OP_BITS{1'b1}};

  logic clk = 1'b0;
  logic rst_n;

  okvt_in_if  #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) op_if ();
  okvt_out_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .CNT_BITS(CNT_BITS)) res_if ();

  ordered_key_value_table #(
    .TABLE_DEPTH(DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (op_if),
    .out_o (res_if)
  );

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;

  okvt_checker #(
    .TABLE_DEPTH(DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CNT_BITS   (CNT_BITS)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .op_i         (op_if),
    .res_i        (res_if),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .compared_o   (compared)
  );

  always #5 clk = ~clk;

  // Flow-control knobs, set per phase by the stimulus process.
  bit source_gaps;
  bit sink_stalls;
  bit hold_req;
  int unsigned held_cycles;

  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  int unsigned         op_tally [1 << OP_BITS];

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cycle limit of %0d reached, %0d results still pending", CYCLE_LIMIT, outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver side. Ready changes on the falling edge only. The long hold-off
  // is counted here so the sender keeps offering while the pipe backs up.
  initial begin
    int unsigned burst;
    res_if.ready = 1'b0;
    held_cycles  = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        res_if.ready = 1'b0;
      end else if (hold_req) begin
        res_if.ready = 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) begin
          @(negedge clk);
          held_cycles++;
        end
        held_cycles++;
        hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12);
        res_if.ready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Offer one operation from the next falling edge and hold it until the transfer.
  task automatic send_op(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                         logic [VALUE_BITS-1:0] value, logic [POS_BITS-1:0] pos);
    @(negedge clk);
    op_if.valid     = 1'b1;
    op_if.operation = op;
    op_if.key_in    = key;
    op_if.value_in  = value;
    op_if.position  = pos;
    op_tally[op]++;
    do @(posedge clk); while (!op_if.ready);
  endtask

  // Drop valid for a number of cycles; the payload is junk meanwhile.
  task automatic idle_source(int unsigned cycles);
    @(negedge clk);
    op_if.valid     = 1'b0;
    op_if.operation = OP_BITS'($urandom());
    op_if.key_in    = $urandom();
    op_if.value_in  = $urandom();
    op_if.position  = POS_BITS'($urandom());
    repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    logic [OP_BITS-1:0]    op;
    logic [KEY_BITS-1:0]   key;
    logic [POS_BITS-1:0]   pos;
    int unsigned           roll;
    int unsigned           insert_share;
    int unsigned           ignored;

    op_if.valid     = 1'b0;
    op_if.operation = OP_INSERT;
    op_if.key_in    = '0;
    op_if.value_in  = '0;
    op_if.position  = '0;
    source_gaps     = 1'b0;
    sink_stalls     = 1'b0;
    hold_req        = 1'b0;
    rst_n           = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part ----
    // empty table: lookup misses and any position is out of range
    send_op(OP_LOOKUP, '0, '0, '0);
    send_op(OP_READ_POS, '0, '0, '0);
    // extreme keys and values, then a duplicate insert and an update
    send_op(OP_INSERT, '0, '0, '0);
    send_op(OP_INSERT, '1, '1, '1);
    send_op(OP_INSERT, '0, 32'h1234_5678, '0);
    send_op(OP_UPDATE, '0, 32'hA5A5_A5A5, '0);
    // fill the rest of the table
    for (int i = 1; i <= DEPTH - 2; i++)
      send_op(OP_INSERT, 32'h0100_0001 * i, $urandom(), '0);
    // full table: new key is refused, but a present key reports present first
    send_op(OP_INSERT, 32'h5555_AAAA, $urandom(), '0);
    send_op(OP_INSERT, '1, $urandom(), '0);
    // oldest slot, then a position far out of range
    send_op(OP_READ_POS, '0, '0, POS_BITS'(DEPTH - 1));
    send_op(OP_READ_POS, '0, '0, '1);
    // erase from the middle closes the gap
    send_op(OP_ERASE, 32'h0100_0001 * 7, '0, '0);
    send_op(OP_LAST_UNUSED, $urandom(), $urandom(), POS_BITS'($urandom()));

    // ---- random part ----
    // Keys mostly come from a small pool so hits, duplicates and a full table
    // are common; odd blocks lean toward erase so the table also drains.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      for (int k = 0; k < 4; k++) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
      source_gaps  = !(blk == 2 || blk == 3 || blk >= RAND_BLOCKS - 2);
      sink_stalls  = !(blk == 3 || blk >= RAND_BLOCKS - 2);
      if (blk == 2) hold_req = 1'b1;
      insert_share = (blk % 2) ? 20 : 35;
      for (int n = 0; n < BLOCK_OPS; n++) begin
        if (source_gaps && $urandom_range(0, 5) == 0) idle_source($urandom_range(1, 12));
        roll = $urandom_range(0, 99);
        if (roll < insert_share)           op = OP_INSERT;
        else if (roll < insert_share + 12) op = OP_UPDATE;
        else if (roll < 65)                op = OP_ERASE;
        else if (roll < 80)                op = OP_LOOKUP;
        else if (roll < 95)                op = OP_READ_POS;
        else op = OP_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : $urandom();
        pos = ($urandom_range(0, 3) == 0) ? POS_BITS'($urandom_range(0, 255))
                                          : POS_BITS'($urandom_range(0, DEPTH + 1));
        send_op(op, key, $urandom(), pos);
      end
    end

    // ---- drain ----
    @(negedge clk);
    op_if.valid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    ignored = 0;
    for (int c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++) ignored += op_tally[c];
    $display("ran %0d inserts, %0d updates, %0d erases, %0d lookups, %0d position reads,",
             op_tally[OP_INSERT], op_tally[OP_UPDATE], op_tally[OP_ERASE],
             op_tally[OP_LOOKUP], op_tally[OP_READ_POS]);
    $display("%0d ignored codes; %0d results compared, receiver held off %0d cycles in one go",
             ignored, compared, held_cycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_if.sv
hw/rtl/okvt_in_stage.sv
hw/rtl/okvt_table.sv
hw/rtl/okvt_out_stage.sv
hw/rtl/ordered_key_value_table.sv
tb/okvt_checker.sv
tb/tb_top.sv
